// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/cmba_pkg.sv
// ----------------------------------------------------------------------------
// Codec mode adaptation package
// Constants, register indexes and the sequencer program.
// ----------------------------------------------------------------------------
package cmba_pkg;

  localparam int DEF_WINDOW_FRAMES = 48;
  localparam int DEF_MAX_MODES     = 4;
  localparam int DEF_COUNT_BITS    = 10;

  localparam int NUM_THRESH = 3;
  localparam int Q_W        = 17;
  localparam int CFG_W      = 17;
  localparam int PC_W       = 4;

  localparam logic [Q_W-1:0] BER_ONE = 17'h10000;

  localparam logic [2:0] REG_LOOP_MODE  = 3'd0;
  localparam logic [2:0] REG_NUM_CODECS = 3'd1;
  localparam logic [2:0] REG_THR0       = 3'd2;
  localparam logic [2:0] REG_THR1       = 3'd3;
  localparam logic [2:0] REG_THR2       = 3'd4;
  localparam logic [2:0] REG_HYS0       = 3'd5;
  localparam logic [2:0] REG_HYS1       = 3'd6;
  localparam logic [2:0] REG_HYS2       = 3'd7;

  localparam logic [1:0] CHG_NONE = 2'd0;
  localparam logic [1:0] CHG_DOWN = 2'd1;
  localparam logic [1:0] CHG_UP   = 2'd2;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_TAKE,
    UOP_BER_PREP,
    UOP_DIV_STEP,
    UOP_BER_STORE,
    UOP_ACC,
    UOP_AVG_PREP,
    UOP_DECIDE,
    UOP_OUT
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_IN,
    COND_BER_SAT,
    COND_DIV_BUSY,
    COND_NO_DECIDE,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    uop_e            op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] STEP_BER_PREP = 4'd1;
  localparam logic [PC_W-1:0] STEP_BER_DIV  = 4'd2;
  localparam logic [PC_W-1:0] STEP_BER_END  = 4'd3;
  localparam logic [PC_W-1:0] STEP_ACC      = 4'd4;
  localparam logic [PC_W-1:0] STEP_AVG_PREP = 4'd5;
  localparam logic [PC_W-1:0] STEP_AVG_DIV  = 4'd6;
  localparam logic [PC_W-1:0] STEP_DECIDE   = 4'd7;
  localparam logic [PC_W-1:0] STEP_OUT      = 4'd8;
  localparam logic [PC_W-1:0] STEP_OUT_WAIT = 4'd9;

  // When the condition holds the sequencer jumps to the target, else it steps on.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    case (pc)
      STEP_IDLE:     cw = '{UOP_TAKE,      COND_NO_IN,     STEP_IDLE};
      STEP_BER_PREP: cw = '{UOP_BER_PREP,  COND_BER_SAT,   STEP_ACC};
      STEP_BER_DIV:  cw = '{UOP_DIV_STEP,  COND_DIV_BUSY,  STEP_BER_DIV};
      STEP_BER_END:  cw = '{UOP_BER_STORE, COND_NEXT,      STEP_IDLE};
      STEP_ACC:      cw = '{UOP_ACC,       COND_NO_DECIDE, STEP_OUT};
      STEP_AVG_PREP: cw = '{UOP_AVG_PREP,  COND_NEXT,      STEP_IDLE};
      STEP_AVG_DIV:  cw = '{UOP_DIV_STEP,  COND_DIV_BUSY,  STEP_AVG_DIV};
      STEP_DECIDE:   cw = '{UOP_DECIDE,    COND_NEXT,      STEP_IDLE};
      STEP_OUT:      cw = '{UOP_OUT,       COND_OUT_FREE,  STEP_IDLE};
      STEP_OUT_WAIT: cw = '{UOP_NOP,       COND_ALWAYS,    STEP_OUT};
      default:       cw = '{UOP_NOP,       COND_ALWAYS,    STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// File: rtl/codec_mode_ber_adaptation_unit.sv
// ----------------------------------------------------------------------------
// Codec mode adaptation unit
// Averages the frame bit error ratio over a window and steps the requested
// codec mode down or up against per-mode thresholds.
// ----------------------------------------------------------------------------
// The unit takes one frame word at a time and returns one result word for it.
// A small microcoded sequencer drives one shared restoring divider, which
// retires one quotient bit per cycle, once for the frame ratio unless that
// ratio saturates and once more for the window average when a frame closes
// the averaging window. A finished result waits in the output register, so
// the next frame is taken while it is still stalled.
module codec_mode_ber_adaptation_unit #(
  parameter int WINDOW_FRAMES = cmba_pkg::DEF_WINDOW_FRAMES,
  parameter int MAX_MODES     = cmba_pkg::DEF_MAX_MODES,
  parameter int COUNT_BITS    = cmba_pkg::DEF_COUNT_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_index_i,
  input  logic [cmba_pkg::CFG_W-1:0] cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [COUNT_BITS-1:0]      error_count_i,
  input  logic [COUNT_BITS-1:0]      bit_count_i,
  input  logic [1:0]                 uplink_mode_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 requested_mode_o,
  output logic [1:0]                 mode_change_o,
  output logic                       decision_made_o,
  output logic [cmba_pkg::Q_W-1:0]   average_ber_o
);

`include "assert_macros.svh"

  localparam int Q_W      = cmba_pkg::Q_W;
  localparam int CNT_W    = $clog2(WINDOW_FRAMES + 2);
  localparam int ACC_W    = Q_W + CNT_W;
  localparam int DR_W     = (COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W;
  localparam int DC_W     = $clog2(Q_W);
  localparam int MODE_CAP = (MAX_MODES < cmba_pkg::NUM_THRESH + 1) ?
                            MAX_MODES : cmba_pkg::NUM_THRESH + 1;

  logic [cmba_pkg::PC_W-1:0] pc_q, pc_d;
  cmba_pkg::ctrl_t           cw;
  logic                      jump;

  logic [1:0]     loop_q;
  logic [2:0]     num_q;
  logic [Q_W-1:0] thr_q [cmba_pkg::NUM_THRESH];
  logic [Q_W-1:0] hys_q [cmba_pkg::NUM_THRESH];

  logic [1:0]       req_q;
  logic [CNT_W-1:0] wc_q;
  logic [ACC_W-1:0] acc_q;

  logic [COUNT_BITS-1:0] errs_q, bits_q;
  logic [1:0]            ul_q;
  logic [Q_W-1:0]        ber_q;
  logic [CNT_W-1:0]      cnt_q;

  logic [DR_W-1:0] rem_q, div_q;
  logic [Q_W-1:0]  shq_q;
  logic [DC_W-1:0] dcnt_q;
  logic [DR_W:0]   div_t, div_dv, div_diff;
  logic            div_ge;
  logic [DR_W-1:0] rem_d;

  logic [1:0]     res_chg_q;
  logic           res_dec_q;
  logic [Q_W-1:0] res_avg_q;

  logic           out_valid_q;
  logic [1:0]     out_req_q, out_chg_q;
  logic           out_dec_q;
  logic [Q_W-1:0] out_avg_q;

  logic             in_acc, out_free, ber_sat, skip, win_done;
  logic [Q_W:0]     ber2;
  logic [ACC_W-1:0] acc_sum;
  logic [CNT_W-1:0] cnt_nx;
  logic [1:0]       dn_idx;
  logic [Q_W-1:0]   thr_dn, thr_up, hys_up;
  logic [2:0]       nc_eff, nc_lim;
  logic             go_dn, go_up;

  assign in_stall_o = (pc_q != cmba_pkg::STEP_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign ber_sat  = (bits_q == '0) || (errs_q > bits_q);
  assign skip     = !loop_q[0] || (ul_q != req_q);
  assign ber2     = loop_q[1] ? {ber_q, 1'b0} : {1'b0, ber_q};
  assign acc_sum  = acc_q + ACC_W'(ber2);
  assign cnt_nx   = wc_q + (loop_q[1] ? CNT_W'(2) : CNT_W'(1));
  assign win_done = (cnt_nx >= CNT_W'(WINDOW_FRAMES));

  assign div_t    = {rem_q, shq_q[Q_W-1]};
  assign div_dv   = {1'b0, div_q};
  assign div_diff = div_t - div_dv;
  assign div_ge   = (div_t >= div_dv);
  assign rem_d    = div_ge ? div_diff[DR_W-1:0] : div_t[DR_W-1:0];

  assign dn_idx = req_q - 2'd1;

  always_comb begin
    case (dn_idx)
      2'd0:    thr_dn = thr_q[0];
      2'd1:    thr_dn = thr_q[1];
      2'd2:    thr_dn = thr_q[2];
      default: thr_dn = '0;
    endcase
    case (req_q)
      2'd0: begin
        thr_up = thr_q[0];
        hys_up = hys_q[0];
      end
      2'd1: begin
        thr_up = thr_q[1];
        hys_up = hys_q[1];
      end
      2'd2: begin
        thr_up = thr_q[2];
        hys_up = hys_q[2];
      end
      default: begin
        thr_up = '0;
        hys_up = '0;
      end
    endcase
  end

  assign nc_eff = (num_q == 3'd0) ? 3'd1 : num_q;
  assign nc_lim = (nc_eff > 3'(MODE_CAP)) ? 3'(MODE_CAP) : nc_eff;
  assign go_dn  = (req_q != 2'd0) && (shq_q > thr_dn);
  assign go_up  = (({1'b0, req_q} + 3'd1) < nc_lim) &&
                  (({1'b0, shq_q} + {1'b0, hys_up}) < {1'b0, thr_up});

  assign cw = cmba_pkg::ucode(pc_q);

  always_comb begin
    case (cw.cond)
      cmba_pkg::COND_NEXT:      jump = 1'b0;
      cmba_pkg::COND_ALWAYS:    jump = 1'b1;
      cmba_pkg::COND_NO_IN:     jump = !in_acc;
      cmba_pkg::COND_BER_SAT:   jump = ber_sat;
      cmba_pkg::COND_DIV_BUSY:  jump = (dcnt_q != '0);
      cmba_pkg::COND_NO_DECIDE: jump = skip || !win_done;
      cmba_pkg::COND_OUT_FREE:  jump = out_free;
      default:                  jump = 1'b0;
    endcase
    pc_d = jump ? cw.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= cmba_pkg::STEP_IDLE;
      loop_q      <= '0;
      num_q       <= 3'd1;
      thr_q       <= '{default: '0};
      hys_q       <= '{default: '0};
      req_q       <= '0;
      wc_q        <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;

      if ((cw.op == cmba_pkg::UOP_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (cw.op)
        cmba_pkg::UOP_ACC: begin
          if (!skip) begin
            acc_q <= acc_sum;
            if (!win_done) begin
              wc_q <= cnt_nx;
            end
          end
        end
        cmba_pkg::UOP_DECIDE: begin
          acc_q <= '0;
          wc_q  <= '0;
          if (go_dn) begin
            req_q <= req_q - 2'd1;
          end else if (go_up) begin
            req_q <= req_q + 2'd1;
          end
        end
        default: begin
        end
      endcase

      if (cfg_we_i) begin
        case (cfg_index_i)
          cmba_pkg::REG_LOOP_MODE: begin
            loop_q <= cfg_data_i[1:0];
            if (!loop_q[0] && cfg_data_i[0]) begin
              acc_q <= '0;
              wc_q  <= '0;
            end
          end
          cmba_pkg::REG_NUM_CODECS: num_q    <= cfg_data_i[2:0];
          cmba_pkg::REG_THR0:       thr_q[0] <= cfg_data_i;
          cmba_pkg::REG_THR1:       thr_q[1] <= cfg_data_i;
          cmba_pkg::REG_THR2:       thr_q[2] <= cfg_data_i;
          cmba_pkg::REG_HYS0:       hys_q[0] <= cfg_data_i;
          cmba_pkg::REG_HYS1:       hys_q[1] <= cfg_data_i;
          cmba_pkg::REG_HYS2:       hys_q[2] <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cw.op)
      cmba_pkg::UOP_TAKE: begin
        if (in_acc) begin
          errs_q <= error_count_i;
          bits_q <= bit_count_i;
          ul_q   <= uplink_mode_i;
        end
      end
      cmba_pkg::UOP_BER_PREP: begin
        ber_q  <= cmba_pkg::BER_ONE;
        rem_q  <= DR_W'(errs_q >> 1);
        shq_q  <= {errs_q[0], {(Q_W-1){1'b0}}};
        div_q  <= DR_W'(bits_q);
        dcnt_q <= DC_W'(Q_W - 1);
      end
      cmba_pkg::UOP_DIV_STEP: begin
        rem_q  <= rem_d;
        shq_q  <= {shq_q[Q_W-2:0], div_ge};
        dcnt_q <= dcnt_q - 1'b1;
      end
      cmba_pkg::UOP_BER_STORE: begin
        ber_q <= shq_q;
      end
      cmba_pkg::UOP_ACC: begin
        cnt_q     <= cnt_nx;
        res_chg_q <= cmba_pkg::CHG_NONE;
        res_dec_q <= 1'b0;
        res_avg_q <= '0;
      end
      cmba_pkg::UOP_AVG_PREP: begin
        rem_q  <= DR_W'(acc_q >> Q_W);
        shq_q  <= acc_q[Q_W-1:0];
        div_q  <= DR_W'(cnt_q);
        dcnt_q <= DC_W'(Q_W - 1);
      end
      cmba_pkg::UOP_DECIDE: begin
        res_dec_q <= 1'b1;
        res_avg_q <= shq_q;
        if (go_dn) begin
          res_chg_q <= cmba_pkg::CHG_DOWN;
        end else if (go_up) begin
          res_chg_q <= cmba_pkg::CHG_UP;
        end else begin
          res_chg_q <= cmba_pkg::CHG_NONE;
        end
      end
      cmba_pkg::UOP_OUT: begin
        if (out_free) begin
          out_req_q <= req_q;
          out_chg_q <= res_chg_q;
          out_dec_q <= res_dec_q;
          out_avg_q <= res_avg_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign requested_mode_o = out_req_q;
  assign mode_change_o    = out_chg_q;
  assign decision_made_o  = out_dec_q;
  assign average_ber_o    = out_avg_q;

  `ASSERT_SAME(a_window_bound, clk_i, rst_ni, 1'b1, wc_q < CNT_W'(WINDOW_FRAMES),
               "window count out of range")
  `ASSERT_SAME(a_div_rem, clk_i, rst_ni,
               (pc_q == cmba_pkg::STEP_BER_DIV) || (pc_q == cmba_pkg::STEP_AVG_DIV),
               rem_q < div_q, "divider remainder not below divisor")
  `ASSERT_NEXT(a_req_hold, clk_i, rst_ni, pc_q != cmba_pkg::STEP_DECIDE, $stable(req_q),
               "request changed outside a decision")
  `ASSERT_SAME(a_no_decision, clk_i, rst_ni, out_valid_o && !decision_made_o,
               (mode_change_o == cmba_pkg::CHG_NONE) && (average_ber_o == '0),
               "result word without decision carries a change")

endmodule
